// File: hw/rtl/ses_pkg.sv
// shared types and constants for the encoder speed estimator
`timescale 1ns / 1ps

package ses_pkg;

    // number of wheels handled side by side
    localparam int NUM_WHEELS = 2;

    // field widths
    localparam int COUNT_W = 31;
    localparam int SPEED_W = 32;
    localparam int MOD_W   = 32;
    localparam int DPC_W   = 24;
    localparam int GAIN_W  = 17;
    localparam int RATE_W  = 16;
    localparam int FILT_W  = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 64;

    // unity filter gain in Q1.16
    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENCODER_MODULUS    = 3'd0,
        CFG_DISTANCE_PER_COUNT = 3'd1,
        CFG_FILTER_GAIN        = 3'd2,
        CFG_SAMPLE_RATE        = 3'd3
    } cfg_index_t;

    // reset values of the configuration registers
    localparam logic [MOD_W-1:0]  MODULUS_RST = 32'd1073741827;
    localparam logic [DPC_W-1:0]  DPC_RST     = 24'd18392;
    localparam logic [GAIN_W-1:0] GAIN_RST    = 17'd13107;
    localparam logic [RATE_W-1:0] RATE_RST    = 16'd100;

    // configuration as seen by the lanes
    typedef struct packed {
        logic [MOD_W-1:0]  modulus;
        logic [DPC_W-1:0]  dist_per_count;
        logic [GAIN_W-1:0] gain;
        logic [RATE_W-1:0] rate;
    } ses_cfg_t;

    // sequencer states, one per lane step
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIST,
        ST_DIFF,
        ST_PROD,
        ST_FILT,
        ST_SPD,
        ST_OUT
    } ses_state_t;

    // step enables from the sequencer to the lanes and the output stage
    typedef struct packed {
        logic cap;
        logic scale;
        logic diff;
        logic prod;
        logic filt;
        logic spd;
        logic out;
    } ses_step_t;

endpackage

// File: hw/rtl/encoder_speed_estimator_top.sv
// Wheel speed estimator top level: each input transaction carries the left
// and right encoder counts of one sample tick and yields one result
// transaction with both filtered speeds in Q23.8 mm/s. Both wheels run in
// lock step in their own lane, driven by one step sequencer: each tick runs
// the capture, scale, difference, product, filter and speed steps and waits
// for room in the output register; the next input is taken once the result
// has moved into that register, so no tick is taken while one is in work.
// The filter's split multiplies and recombine each take a lane step.
// Configuration writes are meant for idle periods.
`timescale 1ns / 1ps

module encoder_speed_estimator_top
    import ses_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input samples
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // left_count[30:0], right_count[61:31]
    // speed results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata   // left_speed[31:0], right_speed[63:32]
);

    ses_cfg_t           cfg_reg;
    ses_step_t          step;
    logic               out_room;
    logic [COUNT_W-1:0] count [NUM_WHEELS];
    logic [SPEED_W-1:0] speed [NUM_WHEELS];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus        <= MODULUS_RST;
            cfg_reg.dist_per_count <= DPC_RST;
            cfg_reg.gain           <= GAIN_RST;
            cfg_reg.rate           <= RATE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_ENCODER_MODULUS:    cfg_reg.modulus        <= cfg_wdata[MOD_W-1:0];
                CFG_DISTANCE_PER_COUNT: cfg_reg.dist_per_count <= cfg_wdata[DPC_W-1:0];
                CFG_FILTER_GAIN:        cfg_reg.gain           <= cfg_wdata[GAIN_W-1:0];
                CFG_SAMPLE_RATE:        cfg_reg.rate           <= cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // step sequencer
    ses_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .out_room (out_room),
        .in_ready (s_axis_tready),
        .step     (step)
    );

    // one lane per wheel
    for (genvar w = 0; w < NUM_WHEELS; w++) begin : g_lane
        assign count[w] = s_axis_tdata[w*COUNT_W +: COUNT_W];

        ses_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .step    (step),
            .cfg     (cfg_reg),
            .count   (count[w]),
            .speed   (speed[w])
        );
    end

    // result register
    ses_merge u_merge (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (step.out),
        .speed         (speed),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .room          (out_room)
    );

endmodule

// File: hw/rtl/ses_ctrl.sv
// step sequencer shared by the wheel lanes
`timescale 1ns / 1ps

module ses_ctrl
    import ses_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  logic      out_room,
    output logic      in_ready,
    output ses_step_t step
);

    ses_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and step enables
    always_comb begin
        state_next = state_reg;
        step       = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    step.cap   = 1'b1;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                step.scale = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                step.diff  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                step.prod  = 1'b1;
                state_next = ST_FILT;
            end
            ST_FILT: begin
                step.filt  = 1'b1;
                state_next = ST_SPD;
            end
            ST_SPD: begin
                step.spd   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // hold here until the output register can take the result
                if (out_room) begin
                    step.out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/ses_lane.sv
// one wheel: delta with wrap correction, scaling, low-pass filter and speed
`timescale 1ns / 1ps

module ses_lane
    import ses_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  ses_step_t                 step,
    input  ses_cfg_t                  cfg,
    input  logic [COUNT_W-1:0]        count,
    output logic signed [SPEED_W-1:0] speed
);

    logic [COUNT_W-1:0]       prev_reg;
    logic signed [FILT_W-1:0] filt_reg, filt_next;
    logic signed [31:0]       dc_reg, dc_next;
    logic signed [FILT_W-1:0] dist_reg, dist_next;
    logic signed [48:0]       diff_reg, diff_next;
    logic [40:0]              plo_reg, plo_next;
    logic signed [42:0]       phi_reg, phi_next;
    logic [39:0]              slo_reg, slo_next;
    logic signed [40:0]       shi_reg, shi_next;

    logic signed [33:0] d_raw, d_sub, d_add, half_s, d_sel;
    logic signed [56:0] dprod;
    logic [GAIN_W-1:0]  gain_cl;
    logic [67:0]        acc;
    logic [67:0]        sp_sum;
    logic [59:0]        sp_shift;

    // delta against previous count, corrected for counter wrap
    always_comb begin
        d_raw  = $signed({3'b000, count}) - $signed({3'b000, prev_reg});
        half_s = $signed({3'b000, cfg.modulus[MOD_W-1:1]});
        d_sub  = d_raw - $signed({2'b00, cfg.modulus});
        d_add  = d_raw + $signed({2'b00, cfg.modulus});
        priority if (d_raw > half_s) begin
            d_sel = d_sub;
        end else if (d_raw < -half_s) begin
            d_sel = d_add;
        end else begin
            d_sel = d_raw;
        end
        // corrected delta always fits 32 bits signed
        dc_next = d_sel[31:0];
    end

    // scale to distance, saturate to 48 bits
    always_comb begin
        dprod = dc_reg * $signed({1'b0, cfg.dist_per_count});
        if (dprod[56:47] == {10{dprod[56]}}) begin
            dist_next = dprod[47:0];
        end else if (dprod[56]) begin
            dist_next = {1'b1, {(FILT_W-1){1'b0}}};
        end else begin
            dist_next = {1'b0, {(FILT_W-1){1'b1}}};
        end
    end

    // filter as filt + g * (dist - filt), product split in two halves
    assign gain_cl   = cfg.gain[GAIN_W-1] ? GAIN_ONE : cfg.gain;
    assign diff_next = $signed({dist_reg[FILT_W-1], dist_reg})
                     - $signed({filt_reg[FILT_W-1], filt_reg});
    assign plo_next  = 41'(diff_reg[23:0] * gain_cl);
    assign phi_next  = $signed(diff_reg[48:24]) * $signed({1'b0, gain_cl});

    // recombine, round half up by 16
    assign acc = {{4{filt_reg[FILT_W-1]}}, filt_reg, 16'h0000}
               + {phi_reg[42], phi_reg, 24'h000000}
               + {27'd0, plo_reg}
               + 68'd32768;
    assign filt_next = acc[63:16];

    // speed products, filter value split in two halves
    assign slo_next = 40'(filt_reg[23:0] * cfg.rate);
    assign shi_next = $signed(filt_reg[47:24]) * $signed({1'b0, cfg.rate});

    // recombine, round half up by 8, saturate to 32 bits
    assign sp_sum   = {{3{shi_reg[40]}}, shi_reg, 24'h000000}
                    + {28'd0, slo_reg}
                    + 68'd128;
    assign sp_shift = sp_sum[67:8];
    always_comb begin
        if (sp_shift[59:31] == {29{sp_shift[59]}}) begin
            speed = sp_shift[31:0];
        end else if (sp_shift[59]) begin
            speed = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            speed = {1'b0, {(SPEED_W-1){1'b1}}};
        end
    end

    // wheel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            filt_reg <= '0;
        end else begin
            if (step.cap) begin
                prev_reg <= count;
            end
            if (step.filt) begin
                filt_reg <= filt_next;
            end
        end
    end

    // pipeline step registers
    always_ff @(posedge aclk) begin
        if (step.cap) begin
            dc_reg <= dc_next;
        end
        if (step.scale) begin
            dist_reg <= dist_next;
        end
        if (step.diff) begin
            diff_reg <= diff_next;
        end
        if (step.prod) begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (step.spd) begin
            slo_reg <= slo_next;
            shi_reg <= shi_next;
        end
    end

endmodule

// File: hw/rtl/ses_merge.sv
// joins the lane speeds into one result transaction and holds it
`timescale 1ns / 1ps

module ses_merge
    import ses_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [SPEED_W-1:0]          speed [NUM_WHEELS],
    input  logic                        m_axis_tready,
    output logic                        m_axis_tvalid,
    output logic [M_TDATA_W-1:0]        m_axis_tdata,
    output logic                        room
);

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg, data_next;

    // pack lane results, first wheel in the low bits
    always_comb begin
        data_next = '0;
        for (int i = 0; i < NUM_WHEELS; i++) begin
            data_next[i*SPEED_W +: SPEED_W] = speed[i];
        end
    end

    assign room = !valid_reg || m_axis_tready;

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;

endmodule

// File: hw/rtl/ses_checker.sv
// port-level checks for the encoder speed estimator
`timescale 1ns / 1ps

module ses_checker
    import ses_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_axis_tvalid,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && s_axis_tready)
        else $error("result pending or input closed after reset");

    // an accepted sample keeps the input closed while the lanes work
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input reopened right after a transaction");

    // no result appears in the cycle right after an input transaction
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared too early");

    // a stalled result holds its value
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind encoder_speed_estimator_top ses_checker u_ses_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: dv/tb_encoder_speed_estimator_top.sv
// testbench for the encoder speed estimator: directed and random ticks against a predictor
`timescale 1ns / 1ps

module tb_encoder_speed_estimator_top;
    import ses_pkg::*;

    localparam int  LEFT_WHEEL      = 0;
    localparam int  RIGHT_WHEEL     = 1;
    localparam int  GAIN_FRAC       = 16;
    localparam int  SPEED_FRAC      = 8;
    localparam int  RANDOM_PHASES   = 6;
    localparam int  ITEMS_PER_PHASE = 142;
    localparam int  SETTLE_CYCLES   = 16;
    localparam int  HOLD_AT         = 80;
    localparam int  HOLD_LEN        = 300;
    localparam int  CYCLE_LIMIT     = 400000;

    localparam longint DIST_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint DIST_MIN  = -DIST_MAX - 1;
    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -SPEED_MAX - 1;

    localparam logic [COUNT_W-1:0]   COUNT_MAX    = '1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

    // expected wheel speeds, worked out per accepted sample tick
    class speed_scoreboard;
        logic [MOD_W-1:0]     modulus;
        logic [DPC_W-1:0]     dist_per_count;
        logic [GAIN_W-1:0]    gain;
        logic [RATE_W-1:0]    rate;
        logic [COUNT_W-1:0]   last_count [NUM_WHEELS];
        longint               filt_dist [NUM_WHEELS];
        logic [M_TDATA_W-1:0] expected_speeds [$];
        int                   errors;

        function new();
            modulus        = MODULUS_RST;
            dist_per_count = DPC_RST;
            gain           = GAIN_RST;
            rate           = RATE_RST;
            errors         = 0;
            for (int w = 0; w < NUM_WHEELS; w++) begin
                last_count[w] = '0;
                filt_dist[w]  = 0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ENCODER_MODULUS:    modulus        = data[MOD_W-1:0];
                CFG_DISTANCE_PER_COUNT: dist_per_count = data[DPC_W-1:0];
                CFG_FILTER_GAIN:        gain           = data[GAIN_W-1:0];
                CFG_SAMPLE_RATE:        rate           = data[RATE_W-1:0];
                default: ;
            endcase
        endfunction

        // wrap-corrected delta, scale, low-pass and rate multiply for one wheel
        function logic [SPEED_W-1:0] wheel_speed(int w, logic [COUNT_W-1:0] count);
            longint span, half, diff, dist_q, g, acc, spd;
            span = longint'({32'b0, modulus});
            half = longint'({33'b0, modulus[MOD_W-1:1]});
            diff = longint'({33'b0, count}) - longint'({33'b0, last_count[w]});
            last_count[w] = count;
            if (diff > half)
                diff -= span;
            else if (diff < -half)
                diff += span;
            dist_q = diff * longint'({40'b0, dist_per_count});
            if (dist_q > DIST_MAX)
                dist_q = DIST_MAX;
            else if (dist_q < DIST_MIN)
                dist_q = DIST_MIN;
            // gain above unity is clamped to unity
            g = longint'({47'b0, (gain > GAIN_ONE) ? GAIN_ONE : gain});
            acc = g * dist_q + (longint'({47'b0, GAIN_ONE}) - g) * filt_dist[w];
            filt_dist[w] = (acc + (64'sd1 <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
            spd = (filt_dist[w] * longint'({48'b0, rate}) + (64'sd1 <<< (SPEED_FRAC - 1)))
                  >>> SPEED_FRAC;
            if (spd > SPEED_MAX)
                spd = SPEED_MAX;
            else if (spd < SPEED_MIN)
                spd = SPEED_MIN;
            return spd[SPEED_W-1:0];
        endfunction

        function void note_sample(logic [COUNT_W-1:0] left, logic [COUNT_W-1:0] right);
            logic [SPEED_W-1:0] left_spd, right_spd;
            left_spd  = wheel_speed(LEFT_WHEEL, left);
            right_spd = wheel_speed(RIGHT_WHEEL, right);
            expected_speeds.push_back({right_spd, left_spd});
        endfunction

        function void check_speeds(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            if (expected_speeds.size() == 0) begin
                $error("result transaction with nothing expected, tdata %h", got);
                errors++;
                return;
            end
            want = expected_speeds.pop_front();
            if (got[SPEED_W-1:0] !== want[SPEED_W-1:0]) begin
                $error("left_speed mismatch: expected %0d, actual %0d",
                       $signed(want[SPEED_W-1:0]), $signed(got[SPEED_W-1:0]));
                errors++;
            end
            if (got[2*SPEED_W-1:SPEED_W] !== want[2*SPEED_W-1:SPEED_W]) begin
                $error("right_speed mismatch: expected %0d, actual %0d",
                       $signed(want[2*SPEED_W-1:SPEED_W]),
                       $signed(got[2*SPEED_W-1:SPEED_W]));
                errors++;
            end
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // left_count[30:0], right_count[61:31]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // left_speed[31:0], right_speed[63:32]

    speed_scoreboard    sb = new();
    int                 cycle_count     = 0;
    int                 accepted_inputs = 0;
    int                 send_idle_pct   = 0;
    int                 recv_idle_pct   = 0;
    int                 hold_left       = 0;
    bit                 hold_done       = 1'b0;
    logic [COUNT_W-1:0] stim_left       = '0;
    logic [COUNT_W-1:0] stim_right      = '0;

    encoder_speed_estimator_top u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // observe register writes and both transaction channels
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en)
                sb.write_register(cfg_index, cfg_wdata);
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_sample(s_axis_tdata[COUNT_W-1:0], s_axis_tdata[2*COUNT_W-1:COUNT_W]);
                accepted_inputs <= accepted_inputs + 1;
            end
            if (m_axis_tvalid && m_axis_tready)
                sb.check_speeds(m_axis_tdata);
        end
    end

    // result side backpressure, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (!hold_done && accepted_inputs >= HOLD_AT) begin
            m_axis_tready <= 1'b0;
            hold_left     <= HOLD_LEN;
            hold_done     <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(input logic [COUNT_W-1:0] left, input logic [COUNT_W-1:0] right);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - 2 * COUNT_W){1'b0}}, right, left};
        stim_left  = left;
        stim_right = right;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // drop valid and let every expected result come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // register value with random bits above its width
    function automatic logic [CFG_DATA_W-1:0] with_noise(logic [CFG_DATA_W-1:0] value, int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = (width >= CFG_DATA_W) ? '1 : ((32'd1 << width) - 1);
        return (value & keep) | ($urandom() & ~keep);
    endfunction

    // next encoder reading: small moves, sometimes near half a turn, wrapped by the modulus
    function automatic logic [COUNT_W-1:0] next_position(logic [COUNT_W-1:0] pos);
        longint span, reach, step, p;
        span = longint'({32'b0, sb.modulus});
        if (span < 2)
            return COUNT_W'($urandom());
        if ($urandom_range(9) == 0)
            reach = span / 2 + 2;
        else
            reach = (span < 4000) ? span : 4000;
        step = longint'($urandom());
        step = ((step << 16) ^ longint'($urandom())) % (2 * reach + 1) - reach;
        p = (longint'({33'b0, pos}) + step) % span;
        if (p < 0)
            p += span;
        return p[COUNT_W-1:0];
    endfunction

    task automatic run_directed();
        // first tick wraps on a full-scale count, then wrap both ways
        send_sample(COUNT_MAX, 31'd12345);
        send_sample(31'd0, 31'd0);
        send_sample(31'd0, COUNT_MAX);
        send_sample(31'd5, 31'd2);
        send_sample(COUNT_MAX - 31'd3, 31'd40);
        wait_drained();

        // widest modulus and scale, gain above unity, full rate: distance and speed saturate
        write_reg(CFG_ENCODER_MODULUS, 32'h8000_0000);
        write_reg(CFG_DISTANCE_PER_COUNT, 32'hFFFF_FFFF);
        write_reg(CFG_FILTER_GAIN, 32'h0001_FFFF);
        write_reg(CFG_SAMPLE_RATE, 32'h0000_FFFF);
        send_sample(31'h4000_0000, 31'h3FFF_FFFF);
        send_sample(31'd0, COUNT_MAX);
        send_sample(COUNT_MAX, 31'd0);
        wait_drained();
        write_reg(CFG_FILTER_GAIN, {15'b0, GAIN_ONE});
        send_sample(31'd1, 31'd1);
        wait_drained();

        // modulus zero with zero rate, then modulus one
        write_reg(CFG_DISTANCE_PER_COUNT, 32'd18392);
        write_reg(CFG_ENCODER_MODULUS, 32'd0);
        write_reg(CFG_FILTER_GAIN, 32'd32768);
        write_reg(CFG_SAMPLE_RATE, 32'd0);
        send_sample(31'd7, 31'd3);
        send_sample(31'd2, 31'd9);
        wait_drained();
        write_reg(CFG_ENCODER_MODULUS, 32'd1);
        write_reg(CFG_SAMPLE_RATE, 32'd1000);
        send_sample(31'd100, 31'd2);
        send_sample(31'd0, 31'd2);
        wait_drained();

        // counts at and above the modulus, zero gain holds the filter
        write_reg(CFG_ENCODER_MODULUS, 32'd1000);
        write_reg(CFG_FILTER_GAIN, 32'd0);
        send_sample(31'd5000, COUNT_MAX);
        send_sample(31'd999, 31'd1000);
        wait_drained();

        // writes to unused indexes change nothing
        write_reg(CFG_FILTER_GAIN, {15'b0, GAIN_RST});
        for (int i = CFG_SAMPLE_RATE + 1; i <= CFG_IDX_LAST; i++)
            write_reg(i[CFG_IDX_W-1:0], $urandom());
        send_sample(31'd1234, 31'd4321);
    endtask

    task automatic pick_config(input int phase);
        logic [MOD_W-1:0]  span;
        logic [DPC_W-1:0]  dpc;
        logic [GAIN_W-1:0] g;
        logic [RATE_W-1:0] r;
        case (phase)
            1: begin
                span = 32'h8000_0000;
                dpc  = '1;
                g    = GAIN_ONE;
                r    = '1;
            end
            3: begin
                span = 32'd2;
                dpc  = DPC_W'($urandom());
                g    = 17'd1;
                r    = 16'd1;
            end
            default: begin
                case ($urandom_range(3))
                    0:       span = $urandom_range(5000, 2);
                    1:       span = $urandom_range(32'h8000_0000, 2);
                    2:       span = $urandom();
                    default: span = MODULUS_RST;
                endcase
                dpc = $urandom_range(1) ? DPC_W'($urandom()) : DPC_W'($urandom_range(40000, 1000));
                g   = ($urandom_range(3) == 0) ? GAIN_W'($urandom())
                                               : GAIN_W'($urandom_range(GAIN_ONE));
                r   = $urandom_range(1) ? RATE_W'($urandom()) : RATE_W'($urandom_range(1000, 1));
            end
        endcase
        write_reg(CFG_ENCODER_MODULUS, with_noise(span, MOD_W));
        write_reg(CFG_DISTANCE_PER_COUNT, with_noise(CFG_DATA_W'(dpc), DPC_W));
        write_reg(CFG_FILTER_GAIN, with_noise(CFG_DATA_W'(g), GAIN_W));
        write_reg(CFG_SAMPLE_RATE, with_noise(CFG_DATA_W'(r), RATE_W));
    endtask

    // mostly plausible encoder motion, some arbitrary counts
    task automatic run_samples(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 12)
                send_sample(COUNT_W'($urandom()), COUNT_W'($urandom()));
            else
                send_sample(next_position(stim_left), next_position(stim_right));
        end
    endtask

    // reset, directed ticks, then random phases under changing idling
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            send_idle_pct = (phase < 2) ? 36 : (phase < 4) ? 55 : 0;
            recv_idle_pct = (phase < 2) ? 55 : (phase < 4) ? 36 : 0;
            pick_config(phase);
            run_samples(ITEMS_PER_PHASE);
        end
        wait_drained();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
